FILE: hdl/abl_pkg.sv
// Package for the adaptive Butterworth low-pass filter.
// Types, register indexes and fixed constants; no dependencies.
`default_nettype none

package abl_pkg;

   // Register indexes of the configuration port
   localparam logic [1:0] CSR_CUTOFF   = 2'd0;
   localparam logic [1:0] CSR_PERIOD   = 2'd1;
   localparam logic [1:0] CSR_ADAPTIVE = 2'd2;

   localparam int CSR_DATA_W  = 32;
   localparam int CSR_INDEX_W = 2;

   // Reset values of the registers
   localparam logic [31:0] CUTOFF_RESET   = 32'd144134;
   localparam logic [19:0] PERIOD_RESET   = 20'd1000;
   localparam logic        ADAPTIVE_RESET = 1'b1;

   // 2*sqrt(2) in Q2.30
   localparam logic [31:0] SQRT2X2_Q30 = 32'd3037000500;

   // Alpha = (256p + 500000) / 1e6, taken as (4p + 7812) / 15625; the
   // reciprocal is floor(2^44 / 15625) + 1, exact for dividends below 2^30
   localparam logic [13:0] ALPHA_BIAS      = 14'd7812;
   localparam logic [29:0] ALPHA_DIVISOR   = 30'd15625;
   localparam logic [30:0] ALPHA_RECIP     = 31'd1125899907;
   localparam logic [65:0] ALPHA_SAT_LIMIT = 66'd67108864000000;

   // Divider quotient width
   localparam logic [5:0] QW_COEF  = 6'd33;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL_P,
      ST_ALPHA_DIV,
      ST_ALPHA_WAIT,
      ST_MUL_AA,
      ST_MUL_AK,
      ST_DEN,
      ST_COEF_DIV,
      ST_COEF_WAIT,
      ST_MAC,
      ST_MAC_LAST,
      ST_OUT
   } state_type;

   typedef enum logic [1:0] {
      MUL_CUT_DT,
      MUL_ALPHA_SQ,
      MUL_ALPHA_K,
      MUL_TERM
   } mul_op_type;

   typedef struct packed {
      logic       load;
      logic       mul_en;
      mul_op_type mul_op;
      logic       alpha_div_start;
      logic       alpha_store;
      logic       s_store;
      logic       den_load;
      logic       coef_div_start;
      logic       coef_store;
      logic [1:0] coef_idx;
      logic [2:0] term_idx;
      logic       acc_clr;
      logic       acc_add;
      logic       out_load;
   } cmd_type;

   typedef struct packed {
      logic alpha_done;
      logic div_done;
      logic out_free;
   } status_type;

endpackage

`default_nettype wire

FILE: hdl/abl_if.sv
// Handshake channels of the filter: sample request and filtered response.
// Stand-alone; no package needed.
`default_nettype none

interface abl_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] sample_value;
   logic [31:0] timestamp_us;

   modport source (output valid, output sample_value, output timestamp_us, input ready);
   modport sink   (input valid, input sample_value, input timestamp_us, output ready);
endinterface

interface abl_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] filtered_value;

   modport source (output valid, output filtered_value, input ready);
   modport sink   (input valid, input filtered_value, output ready);
endinterface

`default_nettype wire

FILE: hdl/adaptive_butterworth_lowpass.sv
// Top level of the adaptive Butterworth low-pass filter.
// Uses abl_pkg, abl_req_if/abl_rsp_if, abl_ctrl and abl_dp.
`default_nettype none

// First- or second-order Butterworth low-pass (bilinear transform) on Q16.16
// samples. Every item recomputes its coefficients from the cutoff and the time
// step (timestamp difference in adaptive mode, else the set period): alpha is
// a constant division done by reciprocal multiplies, a shared radix-2 divider
// computes each of the three (or two) coefficients, and one shared multiplier
// runs the multiply-accumulate over five (or three) taps. One item is in work
// at a time; the next is taken while the previous result waits on rsp.
module adaptive_butterworth_lowpass
   import abl_pkg::*;
#(
   parameter int FILTER_ORDER = 2
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   abl_req_if.sink                     req_if,
   abl_rsp_if.source                   rsp_if,
   input  wire logic                   csr_wr_en,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_data
);

   cmd_type    cmd;
   status_type status;

   abl_ctrl #(.FILTER_ORDER(FILTER_ORDER)) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .status    (status),
      .cmd       (cmd)
   );

   abl_dp #(.FILTER_ORDER(FILTER_ORDER)) u_dp (
      .clock         (clock),
      .reset         (reset),
      .csr_wr_en     (csr_wr_en),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .req_sample    (req_if.sample_value),
      .req_timestamp (req_if.timestamp_us),
      .rsp_valid     (rsp_if.valid),
      .rsp_ready     (rsp_if.ready),
      .rsp_value     (rsp_if.filtered_value),
      .cmd           (cmd),
      .status        (status)
   );

endmodule

`default_nettype wire

FILE: hdl/abl_ctrl.sv
// Sequencer of the filter: walks one item through alpha, coefficients and MAC.
// Uses abl_pkg for state, command and status types.
`default_nettype none

module abl_ctrl
   import abl_pkg::*;
#(
   parameter int FILTER_ORDER = 2
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output      logic       req_ready,
   input  wire status_type status,
   output      cmd_type    cmd
);

   localparam logic [1:0] LAST_COEF = (FILTER_ORDER == 1) ? 2'd1 : 2'd2;
   localparam logic [2:0] LAST_TERM = (FILTER_ORDER == 1) ? 3'd2 : 3'd4;

   state_type  state_ff, state_in;
   logic [1:0] coef_ff, coef_in;
   logic [2:0] term_ff, term_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         coef_ff  <= '0;
         term_ff  <= '0;
      end else begin
         state_ff <= state_in;
         coef_ff  <= coef_in;
         term_ff  <= term_in;
      end
   end

   // Next state and counters
   always_comb begin
      state_in = state_ff;
      coef_in  = coef_ff;
      term_in  = term_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_MUL_P;
         end
         ST_MUL_P:     state_in = ST_ALPHA_DIV;
         ST_ALPHA_DIV: state_in = ST_ALPHA_WAIT;
         ST_ALPHA_WAIT: begin
            if (status.alpha_done) state_in = (FILTER_ORDER == 1) ? ST_DEN : ST_MUL_AA;
         end
         ST_MUL_AA: state_in = ST_MUL_AK;
         ST_MUL_AK: state_in = ST_DEN;
         ST_DEN: begin
            state_in = ST_COEF_DIV;
            coef_in  = '0;
         end
         ST_COEF_DIV: state_in = ST_COEF_WAIT;
         ST_COEF_WAIT: begin
            if (status.div_done) begin
               if (coef_ff == LAST_COEF) begin
                  state_in = ST_MAC;
                  term_in  = '0;
               end else begin
                  state_in = ST_COEF_DIV;
                  coef_in  = coef_ff + 2'd1;
               end
            end
         end
         ST_MAC: begin
            if (term_ff == LAST_TERM) state_in = ST_MAC_LAST;
            else term_in = term_ff + 3'd1;
         end
         ST_MAC_LAST: state_in = ST_OUT;
         ST_OUT: begin
            if (status.out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Commands to the datapath
   always_comb begin
      cmd          = '0;
      cmd.mul_op   = MUL_CUT_DT;
      cmd.coef_idx = coef_ff;
      cmd.term_idx = term_ff;
      req_ready    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         ST_MUL_P: begin
            cmd.mul_en = 1'b1;
            cmd.mul_op = MUL_CUT_DT;
         end
         ST_ALPHA_DIV:  cmd.alpha_div_start = 1'b1;
         ST_ALPHA_WAIT: cmd.alpha_store     = status.alpha_done;
         ST_MUL_AA: begin
            cmd.mul_en = 1'b1;
            cmd.mul_op = MUL_ALPHA_SQ;
         end
         ST_MUL_AK: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_op  = MUL_ALPHA_K;
            cmd.s_store = 1'b1;
         end
         ST_DEN:       cmd.den_load       = 1'b1;
         ST_COEF_DIV:  cmd.coef_div_start = 1'b1;
         ST_COEF_WAIT: cmd.coef_store     = status.div_done;
         ST_MAC: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_op  = MUL_TERM;
            cmd.acc_clr = (term_ff == 3'd0);
            cmd.acc_add = (term_ff != 3'd0);
         end
         ST_MAC_LAST: cmd.acc_add  = 1'b1;
         ST_OUT:      cmd.out_load = status.out_free;
         default: ;
      endcase
   end

endmodule

`default_nettype wire

FILE: hdl/abl_div.sv
// Restoring divider, one quotient bit a cycle, with overflow detection.
// Stand-alone; used by abl_dp for the coefficients.
`default_nettype none

module abl_div (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [63:0] num_hi,
   input  wire logic [32:0] num_lo,
   input  wire logic [5:0]  quo_bits,
   input  wire logic [63:0] den,
   output      logic        done,
   output      logic        ovf,
   output      logic [32:0] quo
);

   logic [63:0] rem_ff, rem_in;
   logic [32:0] lo_ff, lo_in;
   logic [63:0] den_ff;
   logic [5:0]  cnt_ff, cnt_in;
   logic        ovf_ff, done_ff;
   logic [64:0] trial;
   logic        ge;

   // One step: bring down the next bit, subtract where it fits
   always_comb begin
      trial  = {rem_ff, lo_ff[32]};
      ge     = (trial >= {1'b0, den_ff});
      rem_in = ge ? 64'(trial - {1'b0, den_ff}) : trial[63:0];
      lo_in  = {lo_ff[31:0], ge};
      cnt_in = cnt_ff - 6'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else if (start) begin
         cnt_ff  <= quo_bits;
         done_ff <= 1'b0;
      end else begin
         if (cnt_ff != 6'd0) cnt_ff <= cnt_in;
         done_ff <= (cnt_ff == 6'd1);
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= num_hi;
         lo_ff  <= num_lo;
         den_ff <= den;
         ovf_ff <= (num_hi >= den);
      end else if (cnt_ff != 6'd0) begin
         rem_ff <= rem_in;
         lo_ff  <= lo_in;
      end
   end

   assign done = done_ff;
   assign ovf  = ovf_ff;
   assign quo  = lo_ff;

endmodule

`default_nettype wire

FILE: hdl/abl_dp.sv
// Datapath of the filter: registers, history, shared multiplier, divider, MAC.
// Uses abl_pkg and instantiates abl_div.
`default_nettype none

module abl_dp
   import abl_pkg::*;
#(
   parameter int FILTER_ORDER = 2
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_wr_en,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_data,
   input  wire logic [31:0]            req_sample,
   input  wire logic [31:0]            req_timestamp,
   output      logic                   rsp_valid,
   input  wire logic                   rsp_ready,
   output      logic [31:0]            rsp_value,
   input  wire cmd_type                cmd,
   output      status_type             status
);

   localparam logic signed [65:0] NUM_EIGHT = 66'sd1 <<< 49;
   localparam logic signed [65:0] NUM_FOUR  = 66'sd1 <<< 48;
   localparam logic signed [65:0] NUM_TWO   = 66'sd1 <<< 25;

   // Configuration
   logic [31:0] cutoff_ff;
   logic [19:0] period_ff;
   logic        adaptive_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cutoff_ff   <= CUTOFF_RESET;
         period_ff   <= PERIOD_RESET;
         adaptive_ff <= ADAPTIVE_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_CUTOFF:   cutoff_ff   <= csr_data;
            CSR_PERIOD:   period_ff   <= csr_data[19:0];
            CSR_ADAPTIVE: adaptive_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   // Item capture, time step and history
   logic        [31:0] prev_ts_ff, dt_ff;
   logic signed [31:0] x0_ff, xh0_ff, xh1_ff, yh0_ff, yh1_ff;
   logic signed [31:0] y_sat;

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ts_ff <= '0;
         xh0_ff     <= '0;
         xh1_ff     <= '0;
         yh0_ff     <= '0;
         yh1_ff     <= '0;
      end else begin
         if (cmd.load && adaptive_ff) prev_ts_ff <= req_timestamp;
         if (cmd.out_load) begin
            xh0_ff <= x0_ff;
            yh0_ff <= y_sat;
            if (FILTER_ORDER != 1) begin
               xh1_ff <= xh0_ff;
               yh1_ff <= yh0_ff;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         x0_ff <= req_sample;
         dt_ff <= adaptive_ff ? (req_timestamp - prev_ts_ff) : {12'd0, period_ff};
      end
   end

   // Shared multiplier, registered product
   logic signed [31:0] b0_ff, a0_ff, a1_ff, b1;
   logic signed [32:0] mul_a, mul_b;
   logic signed [65:0] prod_ff;
   logic        [31:0] alpha_ff;

   always_comb begin
      if (FILTER_ORDER == 1) b1 = b0_ff;
      else b1 = b0_ff[30] ? 32'sh7FFF_FFFF : {b0_ff[30:0], 1'b0};
   end

   always_comb begin
      mul_a = {1'b0, cutoff_ff};
      mul_b = {1'b0, dt_ff};
      case (cmd.mul_op)
         MUL_CUT_DT: ;
         MUL_ALPHA_SQ: begin
            mul_a = {1'b0, alpha_ff};
            mul_b = {1'b0, alpha_ff};
         end
         MUL_ALPHA_K: begin
            mul_a = {1'b0, alpha_ff};
            mul_b = {1'b0, SQRT2X2_Q30};
         end
         MUL_TERM: begin
            case (cmd.term_idx)
               3'd1: begin
                  mul_a = {b1[31], b1};
                  mul_b = {xh0_ff[31], xh0_ff};
               end
               3'd2: begin
                  mul_a = {a0_ff[31], a0_ff};
                  mul_b = {yh0_ff[31], yh0_ff};
               end
               3'd3: begin
                  mul_a = {b0_ff[31], b0_ff};
                  mul_b = {xh1_ff[31], xh1_ff};
               end
               3'd4: begin
                  mul_a = {a1_ff[31], a1_ff};
                  mul_b = {yh1_ff[31], yh1_ff};
               end
               default: begin
                  mul_a = {b0_ff[31], b0_ff};
                  mul_b = {x0_ff[31], x0_ff};
               end
            endcase
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.mul_en) prod_ff <= mul_a * mul_b;
   end

   // Alpha = (4p + 7812) / 15625 in three 16-bit digits; each digit takes a
   // reciprocal multiply, then a remainder step
   logic [65:0] alp_m;
   logic [60:0] alp_prod;
   logic [29:0] alp_sub;
   logic [13:0] alp_rem;
   logic [29:0] alp_x_ff;
   logic [31:0] alp_src_ff, alp_q_ff;
   logic [15:0] alp_qd_ff;
   logic [2:0]  alp_step_ff;
   logic        alp_sat_ff, alp_done_ff;

   always_comb begin
      alp_m    = {prod_ff[63:0], 2'b00} + {52'd0, ALPHA_BIAS};
      alp_prod = {31'd0, alp_x_ff} * {30'd0, ALPHA_RECIP};
      alp_sub  = alp_x_ff - ({14'd0, alp_qd_ff} * ALPHA_DIVISOR);
      alp_rem  = alp_sub[13:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         alp_step_ff <= '0;
         alp_done_ff <= 1'b0;
      end else if (cmd.alpha_div_start) begin
         alp_step_ff <= 3'd6;
         alp_done_ff <= 1'b0;
      end else begin
         if (alp_step_ff != 3'd0) alp_step_ff <= alp_step_ff - 3'd1;
         alp_done_ff <= (alp_step_ff == 3'd1);
      end
   end

   // even steps take the digit, odd steps the remainder and the next chunk
   always_ff @(posedge clock) begin
      if (cmd.alpha_div_start) begin
         alp_sat_ff <= (alp_m >= ALPHA_SAT_LIMIT);
         alp_x_ff   <= {16'd0, alp_m[45:32]};
         alp_src_ff <= alp_m[31:0];
      end else if (alp_step_ff != 3'd0) begin
         if (!alp_step_ff[0]) begin
            alp_qd_ff <= alp_prod[59:44];
         end else begin
            alp_x_ff   <= {alp_rem, alp_src_ff[31:16]};
            alp_src_ff <= {alp_src_ff[15:0], 16'd0};
            alp_q_ff   <= {alp_q_ff[15:0], alp_qd_ff};
         end
      end
   end

   // Bilinear terms: S = A^2/4, C = A*2sqrt2, denominator
   logic [63:0] s_ff, c_ff, d_ff, c_calc;

   assign c_calc = 64'((prod_ff[63:0] + 64'd128) >> 8);

   always_ff @(posedge clock) begin
      if (cmd.s_store) s_ff <= 64'((prod_ff[63:0] + 64'd2) >> 2);
      if (cmd.den_load) begin
         c_ff <= c_calc;
         if (FILTER_ORDER == 1) d_ff <= {32'd0, alpha_ff} + 64'(NUM_TWO);
         else d_ff <= s_ff + c_calc + 64'(NUM_FOUR);
      end
   end

   // Numerators of the coefficients, taken as sign and magnitude
   logic signed [65:0] s_ext, c_ext, a_ext, coef_num;
   logic               coef_neg;
   logic        [63:0] coef_mag;

   always_comb begin
      s_ext = $signed({2'b00, s_ff});
      c_ext = $signed({2'b00, c_ff});
      a_ext = $signed({34'd0, alpha_ff});
      if (FILTER_ORDER == 1) begin
         coef_num = (cmd.coef_idx == 2'd0) ? a_ext : (NUM_TWO - a_ext);
      end else begin
         case (cmd.coef_idx)
            2'd1:    coef_num = NUM_EIGHT - (s_ext <<< 1);
            2'd2:    coef_num = c_ext - s_ext - NUM_FOUR;
            default: coef_num = s_ext;
         endcase
      end
      coef_neg = coef_num[65];
      coef_mag = coef_neg ? 64'(-coef_num) : coef_num[63:0];
   end

   // Divider operands: coefficients = num*2^31 / D
   logic [63:0] div_hi;
   logic [32:0] div_lo, div_quo;
   logic        div_done, div_ovf;

   assign div_hi = {2'd0, coef_mag[63:2]};
   assign div_lo = {coef_mag[1:0], 31'd0};

   abl_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.coef_div_start),
      .num_hi   (div_hi),
      .num_lo   (div_lo),
      .quo_bits (QW_COEF),
      .den      (d_ff),
      .done     (div_done),
      .ovf      (div_ovf),
      .quo      (div_quo)
   );

   // Rounding and saturation of the quotients
   logic               neg_ff;
   logic        [33:0] mag;
   logic signed [31:0] coef_val;

   always_comb begin
      mag = div_ovf ? 34'h2_0000_0000 : 34'(({1'b0, div_quo} + 34'd1) >> 1);
      if (!neg_ff) coef_val = (mag > 34'h0_7FFF_FFFF) ? 32'sh7FFF_FFFF : mag[31:0];
      else coef_val = (mag > 34'h0_8000_0000) ? 32'sh8000_0000 : -mag[31:0];
   end

   always_ff @(posedge clock) begin
      if (cmd.coef_div_start) neg_ff <= coef_neg;
      if (cmd.alpha_store) alpha_ff <= alp_sat_ff ? 32'hFFFF_FFFF : alp_q_ff;
      if (cmd.coef_store) begin
         case (cmd.coef_idx)
            2'd1:    a0_ff <= coef_val;
            2'd2:    a1_ff <= coef_val;
            default: b0_ff <= coef_val;
         endcase
      end
   end

   // Accumulator: products floored to Q.42, sum rounded to Q16.16
   logic signed [63:0] acc_ff, acc_rnd, y_wide;

   always_ff @(posedge clock) begin
      if (cmd.acc_clr) acc_ff <= '0;
      else if (cmd.acc_add) acc_ff <= acc_ff + 64'(prod_ff >>> 4);
   end

   always_comb begin
      acc_rnd = acc_ff + 64'sd33554432;
      y_wide  = acc_rnd >>> 26;
      if (y_wide > 64'sh7FFF_FFFF) y_sat = 32'sh7FFF_FFFF;
      else if (y_wide < -64'sh8000_0000) y_sat = 32'sh8000_0000;
      else y_sat = y_wide[31:0];
   end

   // Output register
   logic        rsp_valid_ff;
   logic [31:0] rsp_value_ff;

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (cmd.out_load) rsp_valid_ff <= 1'b1;
      else if (rsp_ready) rsp_valid_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) rsp_value_ff <= y_sat;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_value         = rsp_value_ff;
   assign status.alpha_done = alp_done_ff;
   assign status.div_done   = div_done;
   assign status.out_free   = !rsp_valid_ff || rsp_ready;

endmodule

`default_nettype wire

FILE: test/abl_checker.sv
// Checker for the adaptive Butterworth low-pass filter: watches the sample,
// result and register channels, predicts each filtered item and compares.
// Depends on abl_pkg and the abl_req_if/abl_rsp_if interfaces.
`timescale 1ns / 100ps

module abl_checker
   import abl_pkg::*;
#(
   parameter int FILTER_ORDER = 2
) (
   input  logic                   clock,
   input  logic                   reset,
   abl_req_if                     req_mon,
   abl_rsp_if                     rsp_mon,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,
   output int                     fail_count,
   output int                     pending
);

   localparam logic [63:0] ONE_Q46 = 64'd1 << 46;

   // Shadow of the configuration and filter history
   logic [31:0] cutoff;
   logic [19:0] period;
   logic        adaptive;
   logic [31:0] last_ts;
   longint      x_hist [2];
   longint      y_hist [2];

   logic [31:0] filtered_q [$];

   // round_half_up(n * 2^30 / d), capped once the integer part reaches 4
   function automatic logic [63:0] ratio_q30(logic [63:0] n, logic [63:0] d);
      logic [63:0] q;
      logic [63:0] rem;
      q   = n / d;
      rem = n % d;
      if (q >= 64'd4) return 64'd1 << 33;
      for (int i = 0; i < 31; i++) begin
         rem = rem << 1;
         q   = q << 1;
         if (rem >= d) begin
            rem = rem - d;
            q[0] = 1'b1;
         end
      end
      return (q + 64'd1) >> 1;
   endfunction

   // Signed Q2.30 coefficient, magnitude saturated before the sign goes on
   function automatic longint coef_q30(longint num, logic [63:0] den);
      logic [63:0] mag;
      if (num >= 0) begin
         mag = ratio_q30(num, den);
         return (mag > 64'h7FFF_FFFF) ? 64'sh7FFF_FFFF : longint'(mag);
      end
      mag = ratio_q30(64'(-(num + 1)) + 64'd1, den);
      return (mag > 64'h8000_0000) ? -64'sh8000_0000 : -longint'(mag);
   endfunction

   // One filter step: updates the shadow history, returns the output sample
   function automatic logic [31:0] filter_step(logic [31:0] sample, logic [31:0] ts);
      longint      x0;
      logic [63:0] dt, p, q, r, alpha, s, c, d;
      longint      b0, b1, b2, a0, a1, acc, y;
      x0 = longint'(signed'(sample));
      if (adaptive) begin
         dt = 64'(32'(ts - last_ts));
         last_ts = ts;
      end else begin
         dt = 64'(period);
      end
      p = 64'(cutoff) * dt;
      q = p / 64'd1000000;
      r = p % 64'd1000000;
      if (q >= (64'd1 << 24)) alpha = 64'hFFFF_FFFF;
      else begin
         alpha = (q << 8) + (r * 64'd256 + 64'd500000) / 64'd1000000;
         if (alpha > 64'hFFFF_FFFF) alpha = 64'hFFFF_FFFF;
      end
      b2 = 0;
      a1 = 0;
      if (FILTER_ORDER == 1) begin
         d  = alpha + (64'd2 << 24);
         b0 = coef_q30(longint'(alpha), d);
         b1 = b0;
         a0 = coef_q30(longint'(64'd2 << 24) - longint'(alpha), d);
      end else begin
         s  = (alpha * alpha + 64'd2) >> 2;
         c  = (alpha * 64'(SQRT2X2_Q30) + 64'd128) >> 8;
         d  = s + c + 64'd4 * ONE_Q46;
         b0 = coef_q30(longint'(s), d);
         b1 = 2 * b0;
         if (b1 > 64'sh7FFF_FFFF) b1 = 64'sh7FFF_FFFF;
         b2 = b0;
         a0 = coef_q30(longint'(64'd8 * ONE_Q46) - 2 * longint'(s), d);
         a1 = coef_q30(-(longint'(s) - longint'(c) + longint'(64'd4 * ONE_Q46)), d);
      end
      acc = ((b0 * x0) >>> 4) + ((b1 * x_hist[0]) >>> 4) + ((a0 * y_hist[0]) >>> 4);
      if (FILTER_ORDER != 1)
         acc += ((b2 * x_hist[1]) >>> 4) + ((a1 * y_hist[1]) >>> 4);
      y = (acc + (64'sd1 <<< 25)) >>> 26;
      if (y > 64'sh7FFF_FFFF) y = 64'sh7FFF_FFFF;
      if (y < -64'sh8000_0000) y = -64'sh8000_0000;
      if (FILTER_ORDER != 1) begin
         x_hist[1] = x_hist[0];
         y_hist[1] = y_hist[0];
      end
      x_hist[0] = x0;
      y_hist[0] = y;
      return y[31:0];
   endfunction

   always @(posedge clock) begin
      logic [31:0] want;
      if (reset) begin
         cutoff   = CUTOFF_RESET;
         period   = PERIOD_RESET;
         adaptive = ADAPTIVE_RESET;
         last_ts  = '0;
         x_hist   = '{0, 0};
         y_hist   = '{0, 0};
         filtered_q.delete();
      end else begin
         // register writes; unknown indexes are dropped
         if (csr_wr_en) begin
            case (csr_index)
               CSR_CUTOFF:   cutoff   = csr_data;
               CSR_PERIOD:   period   = csr_data[19:0];
               CSR_ADAPTIVE: adaptive = csr_data[0];
               default: ;
            endcase
         end
         if (req_mon.valid && req_mon.ready)
            filtered_q.push_back(filter_step(req_mon.sample_value, req_mon.timestamp_us));
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (filtered_q.size() == 0) begin
               $display("%0t: unexpected item, filtered_value %h", $time,
                        rsp_mon.filtered_value);
               fail_count <= fail_count + 1;
            end else begin
               want = filtered_q.pop_front();
               if (rsp_mon.filtered_value !== want) begin
                  $display("%0t: filtered_value expected %h actual %h", $time, want,
                           rsp_mon.filtered_value);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
      pending <= filtered_q.size();
   end

   initial begin
      fail_count = 0;
      pending    = 0;
   end

endmodule

FILE: test/tb_top.sv
// Testbench top for the adaptive Butterworth low-pass filter: clock, reset,
// register writes and sample stimulus; checking is left to abl_checker.
// Depends on abl_pkg, abl_req_if/abl_rsp_if and the filter RTL.
`timescale 1ns / 100ps

module tb_top;
   import abl_pkg::*;

   localparam int  CYCLE_LIMIT = 2_000_000;
   localparam int  DRAIN_WAIT  = 400;

   logic                   clock;
   logic                   reset;
   logic                   csr_wr_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_data;
   int                     fail_count;
   int                     pending;
   int                     cycles;
   logic                   no_idle;
   logic [31:0]            ts_now;

   abl_req_if req ();
   abl_rsp_if rsp ();

   adaptive_butterworth_lowpass dut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req),
      .rsp_if    (rsp),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   abl_checker chk (
      .clock      (clock),
      .reset      (reset),
      .req_mon    (req),
      .rsp_mon    (rsp),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .fail_count (fail_count),
      .pending    (pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Result side back-pressure
   always @(posedge clock) begin
      if (reset) rsp.ready <= 1'b0;
      else rsp.ready <= no_idle || ($urandom_range(99) >= 30);
   end

   // Watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("adaptive_butterworth_lowpass regression: fail");
         $finish;
      end
   end

   // Leaves the write enable high; callers drop it with csr_done
   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input logic [31:0] val);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
   endtask

   task automatic csr_done();
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   // Present one item; valid stays high afterwards unless a gap follows
   task automatic send_sample(input logic [31:0] val, input logic [31:0] ts);
      if (!no_idle && $urandom_range(99) < 30) begin
         req.valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req.valid        <= 1'b1;
      req.sample_value <= val;
      req.timestamp_us <= ts;
      do @(posedge clock); while (!req.ready);
   endtask

   task automatic drain();
      req.valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
   endtask

   function automatic logic [31:0] rand_sample();
      case ($urandom_range(3))
         0: return $urandom;
         1: return 32'(signed'($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000);
         default: return 32'(signed'($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000);
      endcase
   endfunction

   function automatic logic [31:0] next_ts();
      int pick;
      pick = $urandom_range(99);
      if (pick < 4) return $urandom;
      if (pick < 7) return ts_now;
      return ts_now + $urandom_range(1, 3000);
   endfunction

   initial begin
      logic [31:0] cut;
      logic [31:0] per;
      req.valid        = 1'b0;
      req.sample_value = '0;
      req.timestamp_us = '0;
      rsp.ready        = 1'b0;
      csr_wr_en        = 1'b0;
      csr_index        = '0;
      csr_data         = '0;
      cycles           = 0;
      no_idle          = 1'b0;
      ts_now           = '0;
      reset            = 1'b1;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: sample extremes, repeated timestamp, timestamp wrap
      send_sample(32'h7FFF_FFFF, 32'd1000);
      send_sample(32'h8000_0000, 32'd2000);
      send_sample(32'h0000_0000, 32'd2000);
      send_sample(32'hFFFF_FFFF, 32'd3000);
      send_sample(32'h0001_0000, 32'hFFFF_FFF0);
      send_sample(32'h7FFF_FFFF, 32'h0000_0010);
      drain();

      // Fixed period of zero
      write_reg(CSR_ADAPTIVE, 32'd0);
      write_reg(CSR_PERIOD, 32'd0);
      csr_done();
      send_sample(32'h0010_0000, 32'h1234_5678);
      send_sample(32'h8000_0000, 32'h0);
      drain();

      // Largest period with the largest cutoff: alpha saturates
      write_reg(CSR_PERIOD, 32'h000F_FFFF);
      write_reg(CSR_CUTOFF, 32'hFFFF_FFFF);
      csr_done();
      send_sample(32'h7FFF_FFFF, 32'h0);
      send_sample(32'h8000_0000, 32'h0);
      send_sample(32'h0123_4567, 32'h0);
      drain();

      // Zero cutoff
      write_reg(CSR_CUTOFF, 32'd0);
      write_reg(CSR_PERIOD, 32'd1);
      csr_done();
      send_sample(32'h0040_0000, 32'hAAAA_AAAA);
      send_sample(32'hFFC0_0000, 32'h5555_5555);
      drain();

      // Back to adaptive: step measured from the last stored timestamp;
      // an unused register index is ignored
      write_reg(CSR_ADAPTIVE, 32'd1);
      write_reg(CSR_CUTOFF, CUTOFF_RESET);
      write_reg(2'd3, $urandom);
      csr_done();
      send_sample(32'h0002_0000, 32'h0000_0210);
      send_sample(32'hFFFE_0000, 32'h0000_0400);
      send_sample(32'h0000_8000, 32'h8000_0400);
      drain();

      // Random phases over a spread of settings
      ts_now = 32'h0000_0400;
      for (int ph = 0; ph < 8; ph++) begin
         case (ph)
            0: begin cut = 32'hFFFF_FFFF; per = 32'd1; end
            1: begin cut = 32'd1; per = 32'd1000000; end
            2: begin cut = CUTOFF_RESET; per = PERIOD_RESET; end
            default: begin
               cut = ($urandom_range(3) == 0) ? $urandom
                                              : $urandom_range(32'd6500, 32'd400_000_000);
               per = ($urandom_range(3) == 0) ? $urandom_range(0, 20'hFFFFF)
                                              : $urandom_range(1, 5000);
            end
         endcase
         write_reg(CSR_CUTOFF, cut);
         write_reg(CSR_PERIOD, per);
         write_reg(CSR_ADAPTIVE, (ph == 1 || ph == 5) ? 32'd0 : 32'(ph != 6));
         csr_done();
         no_idle <= (ph == 3);
         for (int n = 0; n < 190; n++) begin
            ts_now = next_ts();
            send_sample(rand_sample(), ts_now);
            // hold the sender off until every result is back
            if (n == 95) drain();
         end
         drain();
         no_idle <= 1'b0;
      end

      repeat (DRAIN_WAIT) @(posedge clock);
      if (fail_count == 0 && pending == 0)
         $display("adaptive_butterworth_lowpass regression: pass");
      else
         $display("adaptive_butterworth_lowpass regression: fail");
      $finish;
   end

endmodule
